// ===== hw/rtl/tscf_pkg.sv =====
// Shared constants, command codes and helpers for the telemetry sentence CRC framer.
// No dependencies; used by tscf_crc16_fold and telemetry_sentence_crc_framer_core.
`default_nettype none

package tscf_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CRC_W   = 16;
   localparam int unsigned NIB_W   = 4;
   localparam int unsigned SEQ_W   = 3;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CRC_W-1:0]  crc_type;
   typedef logic [NIB_W-1:0]  nib_type;
   typedef logic [SEQ_W-1:0]  seq_type;

   localparam cmd_type CMD_APPEND  = 2'd0;
   localparam cmd_type CMD_RESTART = 2'd1;
   localparam cmd_type CMD_FINISH  = 2'd2;

   localparam crc_type CRC_POLY    = 16'h1021;
   localparam crc_type CRC_RESET   = 16'hDEAD;
   localparam crc_type CRC_RESTART = 16'hFFFF;

   localparam byte_type STAR_BYTE     = 8'h2A;
   localparam byte_type NEWLINE_BYTE  = 8'h0A;
   localparam byte_type NUL_BYTE      = 8'h00;
   localparam byte_type ASCII_ZERO    = 8'd48;
   localparam byte_type HEX_ALPHA_GAP = 8'(65 - 48 - 10);

   // trailer sequencer: star is sent on the finish beat, then digits, newline, nul
   localparam seq_type SEQ_IDLE    = 3'd0;
   localparam seq_type SEQ_DIGIT3  = 3'd1;
   localparam seq_type SEQ_DIGIT2  = 3'd2;
   localparam seq_type SEQ_DIGIT1  = 3'd3;
   localparam seq_type SEQ_DIGIT0  = 3'd4;
   localparam seq_type SEQ_NEWLINE = 3'd5;
   localparam seq_type SEQ_NUL     = 3'd6;

   function automatic byte_type hex_char(input nib_type nib);
      byte_type base;
      base = ASCII_ZERO + {4'd0, nib};
      if (nib > 4'd9) begin
         return base + HEX_ALPHA_GAP;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/telemetry_sentence_crc_framer_core.sv =====
// Top level of the telemetry sentence CRC framer: byte echo, running CRC-16, trailer.
// Depends on tscf_pkg and tscf_crc16_fold.
//
//  channel | dir | tdata          | tuser          | tlast
//  req     | in  | data_byte[7:0] | cmd[1:0]       | -
//  rsp     | out | out_byte[7:0]  | link_select[0] | last
//
// An append beat can be taken every cycle while rsp is not stalled; its echo is
// registered and appears in rsp the cycle after. A finish beat emits seven rsp beats;
// req is held off for the six trailer beats after the star. A restart beat emits nothing.
// Reset: CRC = 0xDEAD, link toggle = 0, rsp empty. rsp stalls back up into req
// through the single output register.
`default_nettype none

module telemetry_sentence_crc_framer_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] data_byte
   input  wire  [1:0] req_tuser,   // [1:0] cmd
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] link_select
   output logic       rsp_tlast
);

   tscf_pkg::crc_type  crc_ff, crc_in, crc_folded;
   tscf_pkg::crc_type  cap_ff, cap_in;
   tscf_pkg::seq_type  seq_ff, seq_in;
   logic               toggle_ff, toggle_in;
   logic               link_ff, link_in;
   logic               valid_ff, valid_in;
   tscf_pkg::byte_type byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               lsel_ff, lsel_in;
   logic               slot_free;
   logic               emit;

   tscf_crc16_fold u_fold (
      .crc_cur   (crc_ff),
      .data_byte (byte_in),
      .crc_next  (crc_folded)
   );

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (seq_ff == tscf_pkg::SEQ_IDLE) && slot_free;

   always_comb begin
      emit      = 1'b0;
      byte_in   = tscf_pkg::NUL_BYTE;
      last_in   = 1'b0;
      lsel_in   = 1'b0;
      crc_in    = crc_ff;
      cap_in    = cap_ff;
      seq_in    = seq_ff;
      link_in   = link_ff;
      toggle_in = toggle_ff;

      if (seq_ff != tscf_pkg::SEQ_IDLE) begin
         if (slot_free) begin
            emit   = 1'b1;
            seq_in = seq_ff + 3'd1;
            unique case (seq_ff)
               tscf_pkg::SEQ_DIGIT3:  byte_in = tscf_pkg::hex_char(cap_ff[15:12]);
               tscf_pkg::SEQ_DIGIT2:  byte_in = tscf_pkg::hex_char(cap_ff[11:8]);
               tscf_pkg::SEQ_DIGIT1:  byte_in = tscf_pkg::hex_char(cap_ff[7:4]);
               tscf_pkg::SEQ_DIGIT0:  byte_in = tscf_pkg::hex_char(cap_ff[3:0]);
               tscf_pkg::SEQ_NEWLINE: byte_in = tscf_pkg::NEWLINE_BYTE;
               tscf_pkg::SEQ_NUL: begin
                  byte_in = tscf_pkg::NUL_BYTE;
                  last_in = 1'b1;
                  lsel_in = link_ff;
                  seq_in  = tscf_pkg::SEQ_IDLE;
               end
               default: begin
                  emit   = 1'b0;
                  seq_in = tscf_pkg::SEQ_IDLE;
               end
            endcase
         end
      end else if (req_tvalid && req_tready) begin
         unique case (req_tuser)
            tscf_pkg::CMD_APPEND: begin
               emit    = 1'b1;
               byte_in = req_tdata;
            end
            tscf_pkg::CMD_RESTART: begin
               crc_in = tscf_pkg::CRC_RESTART;
            end
            tscf_pkg::CMD_FINISH: begin
               emit      = 1'b1;
               byte_in   = tscf_pkg::STAR_BYTE;
               cap_in    = crc_ff;
               link_in   = toggle_ff;
               toggle_in = ~toggle_ff;
               seq_in    = tscf_pkg::SEQ_DIGIT3;
            end
            default: ;
         endcase
      end

      if (emit) begin
         crc_in = crc_folded;
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (slot_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= tscf_pkg::CRC_RESET;
         toggle_ff <= 1'b0;
         seq_ff    <= tscf_pkg::SEQ_IDLE;
         valid_ff  <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         toggle_ff <= toggle_in;
         seq_ff    <= seq_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff  <= cap_in;
      link_ff <= link_in;
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         lsel_ff <= lsel_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = lsel_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tscf_crc16_fold.sv =====
// Byte-wide CRC-16 update, poly 0x1021, MSB first, no reflection.
// Depends on tscf_pkg.
`default_nettype none

module tscf_crc16_fold (
   input  wire tscf_pkg::crc_type  crc_cur,
   input  wire tscf_pkg::byte_type data_byte,
   output tscf_pkg::crc_type       crc_next
);

   always_comb begin
      tscf_pkg::crc_type c;
      c = crc_cur ^ {data_byte, 8'd0};
      for (int k = 0; k < 8; k++) begin
         if (c[tscf_pkg::CRC_W-1]) begin
            c = {c[tscf_pkg::CRC_W-2:0], 1'b0} ^ tscf_pkg::CRC_POLY;
         end else begin
            c = {c[tscf_pkg::CRC_W-2:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

`default_nettype wire
